>>> src/cmp_pkg.sv
package cmp_pkg;

	localparam int PIX_W      = 8;
	localparam int FW_W       = 11;
	localparam int CFG_W      = 10;
	localparam int ROW_W      = 10;
	localparam int IDX_W      = 3;
	localparam int LINE_DEPTH = 512;
	localparam int OX_W       = $clog2(LINE_DEPTH);
	localparam int EMIT_W     = 19;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [PIX_W-1:0] SIGN_FLIP = 8'h80;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = 11'd320;
	localparam logic [CFG_W-1:0] CROP_COL_RST    = 10'd104;
	localparam logic [CFG_W-1:0] CROP_ROW_RST    = 10'd64;
	localparam logic [CFG_W-1:0] OUT_WIDTH_RST   = 10'd96;
	localparam logic [CFG_W-1:0] OUT_HEIGHT_RST  = 10'd88;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH = 3'd0,
		REG_CROP_COL    = 3'd1,
		REG_CROP_ROW    = 3'd2,
		REG_OUT_WIDTH   = 3'd3,
		REG_OUT_HEIGHT  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pooled_value;
		logic                    last_of_frame;
	} pooled_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [FW_W-1:0]  value;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_PAIR  = 2'd0,
		OP_UPPER = 2'd1,
		OP_EMIT  = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [PIX_W-1:0] pixel;
		logic [OX_W-1:0]  ox;
		logic             last;
	} op_t;

endpackage

>>> src/cmp_ifs.sv
interface cmp_pixel_if;
	import cmp_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmp_pool_if;
	import cmp_pkg::*;
	logic    valid;
	logic    ready;
	pooled_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmp_cfg_if;
	import cmp_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/cmp_front.sv
module cmp_front
	import cmp_pkg::*;
#(
	parameter int MAX_FRAME_WIDTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	cmp_pixel_if.sink     pixels,
	cmp_cfg_if.sink       cfg,
	input  logic          full,
	output logic          push,
	output op_t           op
);

	localparam int CW = $clog2(MAX_FRAME_WIDTH);
	localparam int AW = (CW >= 12) ? CW + 1 : 12;

	logic [FW_W-1:0]   frame_width_q;
	logic [CFG_W-1:0]  crop_col_q, crop_row_q, out_width_q, out_height_q;
	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;
	logic [EMIT_W-1:0] emitted_q;

	logic [CFG_W-1:0]  ow, oh;
	logic [19:0]       prod;
	logic [AW-1:0]     fw_eff, col_x, cc;
	logic [CW-1:0]     col;
	logic [ROW_W-1:0]  row;
	logic [EMIT_W-1:0] emitted, total;
	logic              accept, col_end, in_win, odd_col, odd_row, emit_ok, has_op;

	assign cfg.ready    = 1'b1;
	assign pixels.ready = !full;
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		ow = (out_width_q > CFG_W'(LINE_DEPTH)) ? CFG_W'(LINE_DEPTH) : out_width_q;
		oh = (out_height_q > CFG_W'(LINE_DEPTH)) ? CFG_W'(LINE_DEPTH) : out_height_q;
		prod = {10'd0, ow} * {10'd0, oh};
		total = prod[EMIT_W-1:0];
		if (frame_width_q == '0) begin
			fw_eff = AW'(1);
		end else if (AW'(frame_width_q) > AW'(MAX_FRAME_WIDTH)) begin
			fw_eff = AW'(MAX_FRAME_WIDTH);
		end else begin
			fw_eff = AW'(frame_width_q);
		end
		col     = pixels.data.frame_start ? '0 : col_q;
		row     = pixels.data.frame_start ? '0 : row_q;
		emitted = pixels.data.frame_start ? '0 : emitted_q;
		col_x   = AW'(col);
		col_end = (col_x + AW'(1)) >= fw_eff;
		cc      = col_x - AW'(crop_col_q);
		in_win  = (AW'(row) >= AW'(crop_row_q))
			&& (AW'(row) < AW'(crop_row_q) + AW'({oh, 1'b0}))
			&& (col_x >= AW'(crop_col_q))
			&& (col_x < AW'(crop_col_q) + AW'({ow, 1'b0}));
		odd_col = cc[0];
		odd_row = row[0] ^ crop_row_q[0];
		emit_ok = emitted < total;
		has_op  = !odd_col || !odd_row || emit_ok;
		push    = accept && in_win && has_op;
		if (!odd_col) begin
			op.kind = OP_PAIR;
		end else if (!odd_row) begin
			op.kind = OP_UPPER;
		end else begin
			op.kind = OP_EMIT;
		end
		op.pixel = pixels.data.pixel;
		op.ox    = cc[OX_W:1];
		op.last  = (emitted + EMIT_W'(1)) == total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			crop_col_q    <= CROP_COL_RST;
			crop_row_q    <= CROP_ROW_RST;
			out_width_q   <= OUT_WIDTH_RST;
			out_height_q  <= OUT_HEIGHT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				REG_FRAME_WIDTH: frame_width_q <= cfg.data.value;
				REG_CROP_COL:    crop_col_q    <= cfg.data.value[CFG_W-1:0];
				REG_CROP_ROW:    crop_row_q    <= cfg.data.value[CFG_W-1:0];
				REG_OUT_WIDTH:   out_width_q   <= cfg.data.value[CFG_W-1:0];
				REG_OUT_HEIGHT:  out_height_q  <= cfg.data.value[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else begin
			if (accept) begin
				col_q     <= col_end ? '0 : col + CW'(1);
				row_q     <= col_end ? row + ROW_W'(1) : row;
				emitted_q <= (push && op.kind == OP_EMIT) ? emitted + EMIT_W'(1) : emitted;
			end
		end
	end

endmodule

>>> src/cmp_queue.sv
module cmp_queue
	import cmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  op_in,
	output logic full,
	output logic valid,
	output op_t  op_out,
	input  logic pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	op_t           slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;

	assign full   = count_q == (PW+1)'(QUEUE_DEPTH);
	assign valid  = count_q != '0;
	assign op_out = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("transfer into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid && count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue underflow or count overrun");

endmodule

>>> src/cmp_back.sv
module cmp_back
	import cmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       pop,
	cmp_pool_if.source pooled
);

	logic [PIX_W-1:0] line_q [LINE_DEPTH];
	logic [PIX_W-1:0] pair_q, m, rdata_s1, m_s1, best;
	logic             last_s1, s1_valid_q, out_valid_q, out_free, s1_ready, emit_pop;
	pooled_t          out_q;

	assign out_free  = !out_valid_q || pooled.ready;
	assign s1_ready  = !s1_valid_q || out_free;
	assign pop       = q_valid && (q_op.kind != OP_EMIT || s1_ready);
	assign emit_pop  = pop && q_op.kind == OP_EMIT;
	assign m         = (q_op.pixel > pair_q) ? q_op.pixel : pair_q;
	assign best      = (m_s1 > rdata_s1) ? m_s1 : rdata_s1;
	assign pooled.valid = out_valid_q;
	assign pooled.data  = out_q;

	always_ff @(posedge clk) begin
		if (pop && q_op.kind == OP_UPPER) begin
			line_q[q_op.ox] <= m;
		end
		if (emit_pop) begin
			rdata_s1 <= line_q[q_op.ox];
			m_s1     <= m;
			last_s1  <= q_op.last;
		end
		if (out_free && s1_valid_q) begin
			out_q.pooled_value <= signed'(best ^ SIGN_FLIP);
			out_q.last_of_frame <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q      <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && q_op.kind == OP_PAIR) begin
				pair_q <= q_op.pixel;
			end
			if (s1_ready) begin
				s1_valid_q <= emit_pop;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) emit_pop |=> s1_valid_q)
		else $error("emit lost between queue and stage 1");
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q && $stable(m_s1) && $stable(rdata_s1))
		else $error("stage 1 changed while held");

endmodule

>>> src/crop_maxpool_int8_stream.sv
// channel | role  | payload
// pixels  | sink  | pixel[7:0], frame_start
// pooled  | source| pooled_value[7:0] signed, last_of_frame
// cfg     | sink  | index[2:0], value[10:0]; always ready
// One pixel per cycle while the queue is not full. After leaving the four-entry
// queue, an emit passes the line store read stage, then the output register.
// Reset clears counters, queue, pair maximum and output valid; the line store
// is not cleared and is written before it is read within a frame.
// Output stalls back up through the queue to the pixel input only once it fills.
module crop_maxpool_int8_stream
	import cmp_pkg::*;
#(
	parameter int MAX_FRAME_WIDTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	cmp_pixel_if.sink  pixels,
	cmp_pool_if.source pooled,
	cmp_cfg_if.sink    cfg
);

	op_t  push_op, q_op;
	logic push, full, q_valid, pop;

	cmp_front #(.MAX_FRAME_WIDTH(MAX_FRAME_WIDTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.op     (push_op)
	);

	cmp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.op_in  (push_op),
		.full   (full),
		.valid  (q_valid),
		.op_out (q_op),
		.pop    (pop)
	);

	cmp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop),
		.pooled  (pooled)
	);

endmodule
